@@ src/sssd_pkg.sv @@
// Shared types, constants and lookup functions of the seven-segment scan driver.
package sssd_pkg;

    localparam int DIGITS_DEF = 6;      // default number of digit positions
    localparam int POS_W      = 3;      // scan position width, up to eight positions
    localparam int NUM_W      = 20;     // display number width
    localparam int DOT_W      = 6;      // dot mask width
    localparam int DUR_W      = 8;      // duration width
    localparam int SPS_W      = 16;     // slots per second width
    localparam int CNT_W      = 24;     // slot count and limit width
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int WORD_W     = 16;
    localparam int SEG_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAG_W      = 21;     // reciprocal constant width
    localparam int SH_W       = 6;      // reciprocal shift width
    localparam int PROD_W     = NUM_W + MAG_W;
    localparam int IN_DATA_W  = 40;     // number, dots, duration, padded to bytes

    localparam logic [SPS_W-1:0] SPS_RESET = 16'd1000;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_SCAN    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_STOP    = 2'd2;

    localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

    // q / 10 for q below 2**20: (q * DIV10_MAG) >> DIV10_SH
    localparam logic [MAG_W-1:0] DIV10_MAG = 21'd1677722;
    localparam int               DIV10_SH  = 24;

    typedef struct packed {
        logic               has_scan;      // scan word for one position
        logic               has_blank;     // blank word follows (or stands alone)
        logic [STAT_W-1:0]  blank_status;
        logic               dot;
        logic [POS_W-1:0]   pos;
    } t_ctl;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h27;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // n / 10**k for n below 2**20 is (n * recip_mag(k)) >> recip_sh(k), exact
    function automatic logic [MAG_W-1:0] recip_mag(input logic [POS_W-1:0] k);
        logic [MAG_W-1:0] m;
        unique case (k)
            3'd0:    m = 21'd1048576;
            3'd1:    m = 21'd1677722;
            3'd2:    m = 21'd1342178;
            3'd3:    m = 21'd1073742;
            3'd4:    m = 21'd1717987;
            3'd5:    m = 21'd1374390;
            3'd6:    m = 21'd1099512;
            default: m = 21'd1759219;
        endcase
        return m;
    endfunction

    function automatic logic [SH_W-1:0] recip_sh(input logic [POS_W-1:0] k);
        logic [SH_W-1:0] s;
        unique case (k)
            3'd0:    s = 6'd20;
            3'd1:    s = 6'd24;
            3'd2:    s = 6'd27;
            3'd3:    s = 6'd30;
            3'd4:    s = 6'd34;
            3'd5:    s = 6'd37;
            3'd6:    s = 6'd40;
            default: s = 6'd44;
        endcase
        return s;
    endfunction

endpackage

@@ src/sssd_ctrl.sv @@
// Run control: command decode, slot counting, scan position and the issue register.
module sssd_ctrl #(
    parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sssd_pkg::SPS_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_en,
    input  logic [sssd_pkg::CMD_W-1:0]    i_cmd,
    input  logic [sssd_pkg::NUM_W-1:0]    i_num,
    input  logic [sssd_pkg::DOT_W-1:0]    i_dots,
    input  logic [sssd_pkg::DUR_W-1:0]    i_dur,
    output logic                          o_valid,
    output sssd_pkg::t_ctl                o_ctl,
    output logic [sssd_pkg::NUM_W-1:0]    o_num,
    output logic [sssd_pkg::POS_W-1:0]    o_k
);

    localparam logic [sssd_pkg::POS_W-1:0] LAST_POS = sssd_pkg::POS_W'(DIGITS - 1);

    logic [sssd_pkg::SPS_W-1:0] r_sps;
    logic                       r_running, n_running;
    logic [sssd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [sssd_pkg::CNT_W-1:0] r_count, n_count;
    logic [sssd_pkg::CNT_W-1:0] r_limit, n_limit;
    logic [sssd_pkg::NUM_W-1:0] r_num, n_num;
    logic [sssd_pkg::DOT_W-1:0] r_dots, n_dots;

    logic                       r_valid, n_valid;
    sssd_pkg::t_ctl             r_ctl, n_ctl;
    logic [sssd_pkg::NUM_W-1:0] r_inum;
    logic [sssd_pkg::POS_W-1:0] r_k, n_k;

    logic [sssd_pkg::CNT_W-1:0] count_inc;
    logic [7:0]                 dots_ext;

    assign count_inc = r_count + 1'b1;
    assign dots_ext  = {{(8-sssd_pkg::DOT_W){1'b0}}, r_dots};

    always_comb begin
        n_running = r_running;
        n_pos     = r_pos;
        n_count   = r_count;
        n_limit   = r_limit;
        n_num     = r_num;
        n_dots    = r_dots;
        n_valid   = 1'b0;
        n_ctl     = '0;
        n_k       = LAST_POS - r_pos;
        if (i_accept) begin
            unique case (i_cmd)
                sssd_pkg::CMD_START: begin
                    n_num     = i_num;
                    n_dots    = i_dots;
                    n_limit   = sssd_pkg::CNT_W'(i_dur) * sssd_pkg::CNT_W'(r_sps);
                    n_pos     = '0;
                    n_count   = '0;
                    n_running = 1'b1;
                end
                sssd_pkg::CMD_TICK: begin
                    if (r_running) begin
                        n_valid          = 1'b1;
                        n_ctl.has_scan   = 1'b1;
                        n_ctl.pos        = r_pos;
                        n_ctl.dot        = dots_ext[r_pos];
                        n_pos            = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                        n_count          = count_inc;
                        if (count_inc > r_limit) begin
                            n_running          = 1'b0;
                            n_ctl.has_blank    = 1'b1;
                            n_ctl.blank_status = sssd_pkg::STAT_TIMEOUT;
                        end
                    end
                end
                sssd_pkg::CMD_STOP: begin
                    n_running          = 1'b0;
                    n_valid            = 1'b1;
                    n_ctl.has_blank    = 1'b1;
                    n_ctl.blank_status = sssd_pkg::STAT_STOP;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps     <= sssd_pkg::SPS_RESET;
            r_running <= 1'b0;
            r_pos     <= '0;
            r_count   <= '0;
            r_limit   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sps <= i_cfg_data;
            end
            r_running <= n_running;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_limit   <= n_limit;
            if (i_en) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_dots <= n_dots;
        if (i_en) begin
            r_ctl  <= n_ctl;
            r_inum <= r_num;
            r_k    <= n_k;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_inum;
    assign o_k     = r_k;

endmodule

@@ src/sssd_scan_pipe.sv @@
// Digit extraction and word formatting pipeline with the output register.
module sssd_scan_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sssd_pkg::t_ctl                i_ctl,
    input  logic [sssd_pkg::NUM_W-1:0]    i_num,
    input  logic [sssd_pkg::POS_W-1:0]    i_k,
    input  logic                          i_ready,
    output logic                          o_en,
    output logic                          o_valid,
    output logic [sssd_pkg::WORD_W-1:0]   o_word,
    output logic [sssd_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last
);

    // stage 2: n * reciprocal of 10**k
    logic                          r_v2;
    sssd_pkg::t_ctl                r_ctl2;
    logic [sssd_pkg::PROD_W-1:0]   r_prod2;
    logic [sssd_pkg::SH_W-1:0]     r_sh2;
    // stage 3: quotient and quotient / 10, low nibbles only
    logic                          r_v3;
    sssd_pkg::t_ctl                r_ctl3;
    logic [sssd_pkg::DIGIT_W-1:0]  r_q3;
    logic [sssd_pkg::DIGIT_W-1:0]  r_q10_3;
    // output
    logic                          r_ov;
    sssd_pkg::t_ctl                r_ctlo;
    logic [sssd_pkg::WORD_W-1:0]   r_word;
    logic                          r_second;

    logic [sssd_pkg::PROD_W-1:0]   n_prod2;
    logic [sssd_pkg::NUM_W-1:0]    quot;
    logic [sssd_pkg::PROD_W-1:0]   quot10_prod;
    logic [7:0]                    tens;
    logic [sssd_pkg::DIGIT_W-1:0]  digit;
    logic [sssd_pkg::SEG_W-1:0]    seg;
    logic [7:0]                    sel;
    logic [sssd_pkg::WORD_W-1:0]   n_word;
    logic                          show_scan;
    logic                          last_now;

    assign n_prod2     = sssd_pkg::PROD_W'(i_num) *
                         sssd_pkg::PROD_W'(sssd_pkg::recip_mag(i_k));
    assign quot        = sssd_pkg::NUM_W'(r_prod2 >> r_sh2);
    assign quot10_prod = sssd_pkg::PROD_W'(quot) * sssd_pkg::PROD_W'(sssd_pkg::DIV10_MAG);

    // digit = q - 10 * (q / 10), all mod 16
    assign tens  = ({4'b0, r_q10_3} << 3) + ({4'b0, r_q10_3} << 1);
    assign digit = r_q3 - tens[sssd_pkg::DIGIT_W-1:0];
    assign seg   = sssd_pkg::seg_pattern(digit) | (r_ctl3.dot ? sssd_pkg::DOT_BIT : 8'h00);
    assign sel   = ~(8'd1 << r_ctl3.pos);
    assign n_word = {sel, seg};

    assign show_scan = r_ctlo.has_scan && !r_second;
    assign last_now  = !(show_scan && r_ctlo.has_blank);
    assign o_en      = !r_ov || (i_ready && last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ov     <= 1'b0;
            r_second <= 1'b0;
        end else if (o_en) begin
            r_v2     <= i_valid;
            r_v3     <= r_v2;
            r_ov     <= r_v3;
            r_second <= 1'b0;
        end else if (r_ov && i_ready) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_ctl2  <= i_ctl;
            r_prod2 <= n_prod2;
            r_sh2   <= sssd_pkg::recip_sh(i_k);
            r_ctl3  <= r_ctl2;
            r_q3    <= quot[sssd_pkg::DIGIT_W-1:0];
            r_q10_3 <= quot10_prod[sssd_pkg::DIV10_SH +: sssd_pkg::DIGIT_W];
            r_ctlo  <= r_ctl3;
            r_word  <= n_word;
        end
    end

    assign o_valid  = r_ov;
    assign o_word   = show_scan ? r_word : '0;
    assign o_status = show_scan ? sssd_pkg::STAT_SCAN : r_ctlo.blank_status;
    assign o_last   = last_now;

endmodule

@@ src/seven_segment_scan_driver.sv @@
// Top level of the multiplexed seven-segment scan driver.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  request   | s_tvalid / s_tready       | s_tuser command, s_tdata number, dots, secs
//  result    | m_tvalid / m_tready       | m_tdata segment word, m_tuser status, m_tlast
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_data slots per second
//
//  One request is taken per clock while s_tready is high. A tick passes through the
//  issue register and the reciprocal multiply, divide-by-ten and formatting registers.
//  A tick that times out yields two results and holds the pipe until the second is taken.
//  Reset is synchronous, active low; it stops the scan and restores 1000 slots/s.
//  A result held by m_tready low freezes the whole pipe, and s_tready falls with it.
module seven_segment_scan_driver #(
    parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [19:0] display_number, [25:20] dot_mask, [33:26] duration_seconds, zero pad
    input  logic [sssd_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] command
    input  logic [sssd_pkg::CMD_W-1:0]        s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] segment_word
    output logic [sssd_pkg::WORD_W-1:0]       m_tdata,
    // [1:0] status
    output logic [sssd_pkg::STAT_W-1:0]       m_tuser,
    output logic                              m_tlast,
    // config write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sssd_pkg::SPS_W-1:0]        i_cfg_data
);

    logic                       en;
    logic                       accept;
    logic                       issue_valid;
    sssd_pkg::t_ctl             issue_ctl;
    logic [sssd_pkg::NUM_W-1:0] issue_num;
    logic [sssd_pkg::POS_W-1:0] issue_k;

    assign s_tready    = en;
    assign accept      = s_tvalid && en;
    assign o_cfg_ready = 1'b1;

    sssd_ctrl #(
        .DIGITS (DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_en        (en),
        .i_cmd       (s_tuser),
        .i_num       (s_tdata[19:0]),
        .i_dots      (s_tdata[25:20]),
        .i_dur       (s_tdata[33:26]),
        .o_valid     (issue_valid),
        .o_ctl       (issue_ctl),
        .o_num       (issue_num),
        .o_k         (issue_k)
    );

    // digit extraction, formatting and result hold
    sssd_scan_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (issue_valid),
        .i_ctl    (issue_ctl),
        .i_num    (issue_num),
        .i_k      (issue_k),
        .i_ready  (m_tready),
        .o_en     (en),
        .o_valid  (m_tvalid),
        .o_word   (m_tdata),
        .o_status (m_tuser),
        .o_last   (m_tlast)
    );

    // blank words are all zero
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != sssd_pkg::STAT_SCAN) |-> (m_tdata == '0))
        else $error("blank word not zero");

    // a scan word drives exactly one digit select low
    a_one_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == sssd_pkg::STAT_SCAN) |-> ($countones(~m_tdata[15:8]) == 1))
        else $error("scan word select not one-cold");

    // only a scan word can be followed by another result of the same request
    a_nonlast_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == sssd_pkg::STAT_SCAN))
        else $error("non-final result is not a scan word");

    // the timeout blank directly follows its scan word
    a_timeout_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tlast && m_tuser == sssd_pkg::STAT_TIMEOUT))
        else $error("timeout blank missing after scan word");

    // the input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && (!m_tready || !m_tlast)))
        else $error("input stalled without a pending result");

endmodule
